// ===== design/l2ncm_pkg.sv =====
// Shared constants, types and codes for the L2 norm and channel mean block.
package l2ncm_pkg;

  // Field widths.
  localparam int SAMPLE_BITS = 16;
  localparam int VALUE_BITS  = 22;
  localparam int SUM_BITS    = 42;
  localparam int ACC_BITS    = 24;

  // Configuration register widths and reset values.
  localparam int MODE_BITS      = 1;
  localparam int CC_BITS        = 9;
  localparam int PS_BITS        = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CC_RESET       = 3;
  localparam int PS_RESET       = 1600;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNELS = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE    = 2'd2;

  // Mode codes.
  localparam logic [MODE_BITS-1:0] MODE_L2   = 1'b0;
  localparam logic [MODE_BITS-1:0] MODE_MEAN = 1'b1;

  // Default sizes of the top-level parameters.
  localparam int PLANE_MAX_DEFAULT   = 4096;
  localparam int CHANNEL_MAX_DEFAULT = 256;

  // Step counts of the shared iterative unit.
  localparam int SQRT_STEPS = SUM_BITS / 2;
  localparam int DIV_STEPS  = ACC_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MACC,
    ST_RUN
  } state_t;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } iter_op_t;

  typedef struct packed {
    logic                start;
    iter_op_t            op;
    logic                negative;
    logic [CC_BITS-1:0]  divisor;
    logic [SUM_BITS-1:0] operand;
  } iter_cmd_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } iter_stat_t;

endpackage

// ===== design/l2ncm_stream_ifs.sv =====
// Valid/ready stream interfaces for the element input and the result output.
interface l2ncm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [l2ncm_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   end_of_vector;

  modport source (output valid, output sample, output end_of_vector, input ready);
  modport sink   (input valid, input sample, input end_of_vector, output ready);
endinterface

interface l2ncm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [l2ncm_pkg::VALUE_BITS-1:0] value;
  logic                                  final_flag;

  modport source (output valid, output value, output final_flag, input ready);
  modport sink   (input valid, input value, input final_flag, output ready);
endinterface

// ===== design/l2ncm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module l2ncm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/l2ncm_iter.sv =====
// Shared iterative unit: digit-by-digit square root and restoring division.
module l2ncm_iter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  l2ncm_pkg::iter_cmd_t                   cmd,
  output l2ncm_pkg::iter_stat_t                  stat,
  output logic signed [l2ncm_pkg::VALUE_BITS-1:0] result
);

  localparam int AB = l2ncm_pkg::ACC_BITS;
  localparam int SB = l2ncm_pkg::SUM_BITS;
  localparam int TB = l2ncm_pkg::STEP_BITS;

  logic                          busy;
  logic                          valid;
  l2ncm_pkg::iter_op_t           op_q;
  logic                          neg_q;
  logic [l2ncm_pkg::CC_BITS-1:0] divisor_q;
  logic [SB-1:0]                 src;
  logic [AB-1:0]                 rem;
  logic [AB-1:0]                 acc;
  logic [TB-1:0]                 count;

  logic [AB-1:0] shifted;
  logic [AB-1:0] trial;
  logic [AB:0]   diff;
  logic          ge;
  logic [AB-1:0] signed_q;

  // One subtractor serves both operations; only the operands differ.
  always_comb begin
    unique case (op_q)
      l2ncm_pkg::OP_SQRT: begin
        shifted = {rem[AB-3:0], src[SB-1:SB-2]};
        trial   = {acc[AB-3:0], 2'b01};
      end
      l2ncm_pkg::OP_DIV: begin
        shifted = {rem[AB-2:0], src[SB-1]};
        trial   = AB'(divisor_q);
      end
    endcase
  end

  assign diff = {1'b0, shifted} - {1'b0, trial};
  assign ge   = ~diff[AB];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      valid <= 1'b0;
    end else if (busy && count == '0) begin
      busy  <= 1'b0;
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q      <= cmd.op;
      neg_q     <= cmd.negative;
      divisor_q <= cmd.divisor;
      rem       <= '0;
      acc       <= '0;
      if (cmd.op == l2ncm_pkg::OP_SQRT) begin
        src   <= cmd.operand;
        count <= TB'(l2ncm_pkg::SQRT_STEPS - 1);
      end else begin
        src   <= {cmd.operand[AB-1:0], (SB-AB)'(0)};
        count <= TB'(l2ncm_pkg::DIV_STEPS - 1);
      end
    end else if (busy) begin
      rem   <= ge ? diff[AB-1:0] : shifted;
      acc   <= {acc[AB-2:0], ge};
      src   <= (op_q == l2ncm_pkg::OP_SQRT) ? {src[SB-3:0], 2'b00} : {src[SB-2:0], 1'b0};
      count <= count - TB'(1);
    end
  end

  assign signed_q   = neg_q ? (~acc + AB'(1)) : acc;
  assign result     = signed_q[l2ncm_pkg::VALUE_BITS-1:0];
  assign stat.busy  = busy;
  assign stat.valid = valid;

endmodule

// ===== design/l2_norm_and_channel_mean_unit.sv =====
// Top level of the L2 norm and channel mean reduction block.
//
// Elements arrive on the "elements" stream (valid/ready, one request per
// element) and results leave on the "results" stream. Mode 0 squares each
// signed Q8.8 sample into a saturating 42-bit sum; the element flagged
// end_of_vector produces the integer square root of the sum, a Q8.8 norm.
// Mode 1 takes channel-major planes: channel 0 stores each position in the
// accumulator RAM, later channels add to it, and every position of the last
// channel produces its sum divided by the channel count, truncated toward
// zero. final_flag marks the end of a vector or of a plane.
// An element that only accumulates passes through the square or accumulate
// state and back to idle. An element that ends a vector goes through the
// square, 21 root steps and the output load; an element of the last channel
// goes through the RAM read, the accumulate, 24 quotient steps and the output
// load. The result appears on the stream as the block turns ready again.
// The output register parts the two sides: while a result waits for the
// receiver the block takes the next element, and it only stalls when a new
// result is ready and the old one is still not taken. Reset clears the
// configuration to its defaults and restarts the running sums; the RAM needs
// no clearing pass because channel 0 always writes a position before it is
// read. Each register write also restarts the running vector or plane.
module l2_norm_and_channel_mean_unit #(
  parameter int PLANE_MAX   = l2ncm_pkg::PLANE_MAX_DEFAULT,
  parameter int CHANNEL_MAX = l2ncm_pkg::CHANNEL_MAX_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  l2ncm_in_if.sink                                elements,
  l2ncm_out_if.source                             results,
  input  logic                                    cfg_write,
  input  logic [l2ncm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [l2ncm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int AB  = l2ncm_pkg::ACC_BITS;
  localparam int SB  = l2ncm_pkg::SUM_BITS;
  localparam int XB  = l2ncm_pkg::SAMPLE_BITS;
  localparam int CCB = l2ncm_pkg::CC_BITS;
  localparam int PSB = l2ncm_pkg::PS_BITS;

  // Position index into the accumulator RAM and channel counter widths.
  localparam int AW  = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1;
  localparam int CIW = $clog2(CHANNEL_MAX);

  // Largest counts that both the register width and the parameters allow.
  localparam int CC_LIMIT = (1 << CCB) - 1;
  localparam int CC_CAP   = (CHANNEL_MAX < CC_LIMIT) ? CHANNEL_MAX : CC_LIMIT;
  localparam int PS_LIMIT = (1 << PSB) - 1;
  localparam int PS_CAP   = (PLANE_MAX < PS_LIMIT) ? PLANE_MAX : PS_LIMIT;

  // Compare widths wide enough for both operands plus one.
  localparam int PCW = ((AW > PSB) ? AW : PSB) + 1;
  localparam int CCW = ((CIW > CCB) ? CIW : CCB) + 1;

  // Configuration registers.
  logic [l2ncm_pkg::MODE_BITS-1:0] mode;
  logic [CCB-1:0]                  channel_count;
  logic [PSB-1:0]                  plane_size;

  // Running state.
  l2ncm_pkg::state_t state;
  l2ncm_pkg::state_t state_next;
  logic [SB-1:0]     square_sum;
  logic [AW-1:0]     position_count;
  logic [CIW-1:0]    channel_index;

  // Captured element and result bookkeeping.
  logic signed [XB-1:0] sample_q;
  logic                 eov_q;
  logic [AW-1:0]        pos_q;
  logic                 final_q;

  // Output register.
  logic                                  out_valid;
  logic signed [l2ncm_pkg::VALUE_BITS-1:0] out_value;
  logic                                  out_final;
  logic                                  out_free;
  logic                                  out_load;

  logic accept;
  logic in_ready;

  // Clamped counts.
  logic [CCB-1:0] cc_eff;
  logic [PSB-1:0] ps_eff;
  logic [AW-1:0]  pos_cur;

  // Square path.
  logic signed [2*XB-1:0] square;
  logic [SB:0]            sum_add;
  logic [SB-1:0]          sum_sat;

  // Mean path.
  logic          ram_re;
  logic          ram_we;
  logic [AB-1:0] ram_rdata;
  logic [AB-1:0] sample_ext;
  logic [AB-1:0] total;
  logic [AB-1:0] magnitude;
  logic          last_pos;
  logic          last_ch;

  // Shared unit.
  l2ncm_pkg::iter_cmd_t                  cmd;
  l2ncm_pkg::iter_stat_t                 stat;
  logic signed [l2ncm_pkg::VALUE_BITS-1:0] iter_result;

  assign accept   = elements.valid && in_ready;
  assign out_free = !out_valid || results.ready;

  always_comb begin
    if (channel_count < CCB'(2)) begin
      cc_eff = CCB'(2);
    end else if (channel_count > CCB'(CC_CAP)) begin
      cc_eff = CCB'(CC_CAP);
    end else begin
      cc_eff = channel_count;
    end
    if (plane_size < PSB'(1)) begin
      ps_eff = PSB'(1);
    end else if (plane_size > PSB'(PS_CAP)) begin
      ps_eff = PSB'(PS_CAP);
    end else begin
      ps_eff = plane_size;
    end
  end

  // A position left over from a larger plane starts over at zero.
  assign pos_cur = (PCW'(position_count) >= PCW'(ps_eff)) ? '0 : position_count;

  // Saturating sum of squares.
  assign square  = sample_q * sample_q;
  assign sum_add = {1'b0, square_sum} + (SB+1)'($unsigned(square));
  assign sum_sat = sum_add[SB] ? {SB{1'b1}} : sum_add[SB-1:0];

  // Channel accumulation wraps at the accumulator width.
  assign sample_ext = AB'(sample_q);
  assign total      = (channel_index == '0) ? sample_ext : ram_rdata + sample_ext;
  assign magnitude  = total[AB-1] ? (~total + AB'(1)) : total;
  assign last_pos   = (PCW'(pos_q) + PCW'(1)) == PCW'(ps_eff);
  assign last_ch    = (CCW'(channel_index) + CCW'(1)) >= CCW'(cc_eff);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      l2ncm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (mode == l2ncm_pkg::MODE_MEAN) ? l2ncm_pkg::ST_MACC
                                                       : l2ncm_pkg::ST_SQUARE;
        end
      end
      l2ncm_pkg::ST_SQUARE: begin
        state_next = eov_q ? l2ncm_pkg::ST_RUN : l2ncm_pkg::ST_IDLE;
      end
      l2ncm_pkg::ST_MACC: begin
        state_next = last_ch ? l2ncm_pkg::ST_RUN : l2ncm_pkg::ST_IDLE;
      end
      l2ncm_pkg::ST_RUN: begin
        if (!stat.busy && stat.valid && out_free) begin
          state_next = l2ncm_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready     = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    out_load     = 1'b0;
    cmd.start    = 1'b0;
    cmd.op       = l2ncm_pkg::OP_SQRT;
    cmd.negative = 1'b0;
    cmd.divisor  = cc_eff;
    cmd.operand  = sum_sat;
    unique case (state)
      l2ncm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ram_re   = elements.valid && (mode == l2ncm_pkg::MODE_MEAN);
      end
      l2ncm_pkg::ST_SQUARE: begin
        cmd.start = eov_q;
      end
      l2ncm_pkg::ST_MACC: begin
        ram_we       = 1'b1;
        cmd.start    = last_ch;
        cmd.op       = l2ncm_pkg::OP_DIV;
        cmd.negative = total[AB-1];
        cmd.operand  = SB'(magnitude);
      end
      l2ncm_pkg::ST_RUN: begin
        out_load = !stat.busy && stat.valid && out_free;
      end
    endcase
  end

  // Sequencer, running counters and configuration. A configuration write
  // comes last so that it restarts the run.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= l2ncm_pkg::ST_IDLE;
      mode           <= l2ncm_pkg::MODE_L2;
      channel_count  <= CCB'(l2ncm_pkg::CC_RESET);
      plane_size     <= PSB'(l2ncm_pkg::PS_RESET);
      square_sum     <= '0;
      position_count <= '0;
      channel_index  <= '0;
    end else begin
      state <= state_next;
      if (state == l2ncm_pkg::ST_SQUARE) begin
        square_sum <= eov_q ? '0 : sum_sat;
      end
      if (state == l2ncm_pkg::ST_MACC) begin
        if (last_pos) begin
          position_count <= '0;
          channel_index  <= last_ch ? '0 : channel_index + CIW'(1);
        end else begin
          position_count <= pos_q + AW'(1);
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          l2ncm_pkg::CFG_MODE: begin
            mode           <= cfg_data[l2ncm_pkg::MODE_BITS-1:0];
            square_sum     <= '0;
            position_count <= '0;
            channel_index  <= '0;
          end
          l2ncm_pkg::CFG_CHANNELS: begin
            channel_count  <= cfg_data[CCB-1:0];
            square_sum     <= '0;
            position_count <= '0;
            channel_index  <= '0;
          end
          l2ncm_pkg::CFG_PLANE: begin
            plane_size     <= cfg_data[PSB-1:0];
            square_sum     <= '0;
            position_count <= '0;
            channel_index  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Captured element and the flag that travels with its result.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= elements.sample;
      eov_q    <= elements.end_of_vector;
      pos_q    <= pos_cur;
    end
    if (state == l2ncm_pkg::ST_SQUARE) begin
      final_q <= 1'b1;
    end else if (state == l2ncm_pkg::ST_MACC) begin
      final_q <= last_pos;
    end
  end

  // Output register: it holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= iter_result;
      out_final <= final_q;
    end
  end

  assign elements.ready     = in_ready;
  assign results.valid      = out_valid;
  assign results.value      = out_value;
  assign results.final_flag = out_final;

  // Per-position channel sums.
  l2ncm_ram #(
    .WIDTH (AB),
    .DEPTH (PLANE_MAX)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_q),
    .wdata (total),
    .re    (ram_re),
    .raddr (pos_cur),
    .rdata (ram_rdata)
  );

  // Shared square root and divide unit.
  l2ncm_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .result (iter_result)
  );

endmodule

// ===== test/l2ncm_checker.sv =====
// Checker that predicts and compares every result of the L2 norm and channel mean block.
`timescale 1ns / 100ps
module l2ncm_checker
  import l2ncm_pkg::*;
#(
  parameter int PLANE_MAX   = PLANE_MAX_DEFAULT,
  parameter int CHANNEL_MAX = CHANNEL_MAX_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  l2ncm_in_if                       elements,
  l2ncm_out_if                      results,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        fails,
  output int                        pending
);

  localparam int                  REPORT_LIMIT = 100;
  localparam logic [SUM_BITS-1:0] SUM_CEILING  = '1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         final_flag;
  } outcome_t;

  logic [MODE_BITS-1:0] mode_r;
  logic [CC_BITS-1:0]   channels_r;
  logic [PS_BITS-1:0]   plane_r;
  logic [SUM_BITS-1:0]  square_sum;
  int                   position;
  int                   channel;
  logic [ACC_BITS-1:0]  position_sums [PLANE_MAX];
  outcome_t             awaited[$];

  // Largest root whose square does not exceed the sum, found bit by bit.
  function automatic logic [VALUE_BITS-1:0] root_of(input logic [SUM_BITS-1:0] sum);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = VALUE_BITS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(sum)) root = trial;
    end
    return root[VALUE_BITS-1:0];
  endfunction

  task automatic restart_run();
    square_sum = '0;
    position   = 0;
    channel    = 0;
  endtask

  task automatic predict_reduction(input sample_t sample, input logic last_element);
    longint   sum_wide;
    longint   total;
    longint   quotient;
    int       used_channels;
    int       used_plane;
    logic     plane_done;
    outcome_t fresh;
    if (mode_r == MODE_L2) begin
      sum_wide = longint'(square_sum) + longint'(sample) * longint'(sample);
      if (sum_wide > longint'(SUM_CEILING)) square_sum = SUM_CEILING;
      else square_sum = sum_wide[SUM_BITS-1:0];
      if (last_element) begin
        fresh.value      = root_of(square_sum);
        fresh.final_flag = 1'b1;
        awaited.push_back(fresh);
        square_sum = '0;
      end
    end else begin
      used_channels = channels_r;
      if (used_channels < 2) used_channels = 2;
      if (used_channels > CHANNEL_MAX) used_channels = CHANNEL_MAX;
      used_plane = plane_r;
      if (used_plane < 1) used_plane = 1;
      if (used_plane > PLANE_MAX) used_plane = PLANE_MAX;
      if (position >= used_plane) position = 0;
      plane_done = (position + 1 == used_plane);
      if (channel == 0) total = longint'(sample);
      else total = longint'($signed(position_sums[position])) + longint'(sample);
      position_sums[position] = total[ACC_BITS-1:0];
      if (channel + 1 >= used_channels) begin
        // Signed division truncates toward zero.
        quotient = longint'($signed(position_sums[position])) / longint'(used_channels);
        fresh.value      = quotient[VALUE_BITS-1:0];
        fresh.final_flag = plane_done;
        awaited.push_back(fresh);
        if (plane_done) begin
          position = 0;
          channel  = 0;
        end else begin
          position++;
        end
      end else if (plane_done) begin
        position = 0;
        channel++;
      end else begin
        position++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    outcome_t oldest;
    if (rst) begin
      mode_r     = MODE_L2;
      channels_r = CC_BITS'(CC_RESET);
      plane_r    = PS_BITS'(PS_RESET);
      restart_run();
      awaited.delete();
    end else begin
      // A result leaving at this edge always stems from an earlier request.
      if (results.valid && results.ready) begin
        if (awaited.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $error("unexpected result: value %0d final_flag %0b",
                   results.value, results.final_flag);
        end else begin
          oldest = awaited.pop_front();
          if (results.value !== oldest.value) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $error("value: expected %0d, actual %0d", oldest.value, results.value);
          end
          if (results.final_flag !== oldest.final_flag) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $error("final_flag: expected %0b, actual %0b",
                     oldest.final_flag, results.final_flag);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_MODE: begin
            mode_r = cfg_data[MODE_BITS-1:0];
            restart_run();
          end
          CFG_CHANNELS: begin
            channels_r = cfg_data[CC_BITS-1:0];
            restart_run();
          end
          CFG_PLANE: begin
            plane_r = cfg_data[PS_BITS-1:0];
            restart_run();
          end
          default: ;
        endcase
      end
      if (elements.valid && elements.ready)
        predict_reduction(elements.sample, elements.end_of_vector);
    end
    pending = awaited.size();
  end

endmodule

// ===== test/l2_norm_and_channel_mean_unit_test.sv =====
// Testbench top for the L2 norm and channel mean block: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module l2_norm_and_channel_mean_unit_test;
  import l2ncm_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MIN = sample_t'(-32768);
  localparam sample_t SAMPLE_MAX = sample_t'(32767);

  // Index 3 names no register; a write there must leave everything alone.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS      = 560;
  // Longest time the block may still be working after its last result.
  localparam int SETTLE_CYCLES     = 40;
  localparam int HOLD_OFF_CYCLES   = 400;
  localparam int TIMEOUT_NS        = 12_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int   fail_count;
  int   pending_count;

  // Sender pacing: requests come in bursts; steady suppresses the gaps.
  int   burst_left   = 0;
  logic steady       = 1'b0;
  int   items_sent   = 0;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  logic hold_off_req = 1'b0;

  l2ncm_in_if  elem_ch ();
  l2ncm_out_if res_ch ();

  l2_norm_and_channel_mean_unit dut (
    .clk      (clk),
    .rst      (rst),
    .elements (elem_ch),
    .results  (res_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  l2ncm_checker reduction_check (
    .clk      (clk),
    .rst      (rst),
    .elements (elem_ch),
    .results  (res_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fails    (fail_count),
    .pending  (pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Samples lean toward the extremes and the values around zero, and the
  // rest are uniform over the whole 16-bit range so every bit toggles.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 11))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return '0;
      3: return sample_t'($urandom_range(0, 2)) - sample_t'(1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offers one request at a falling edge and waits for the rising edge that
  // takes it. Valid stays high across back-to-back requests, so it is never
  // lowered and raised in the same time step.
  task automatic send_item(input sample_t sample, input logic last_element);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        elem_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    elem_ch.valid         <= 1'b1;
    elem_ch.sample        <= sample;
    elem_ch.end_of_vector <= last_element;
    do @(posedge clk); while (!elem_ch.ready);
    items_sent++;
  endtask

  // Stops offering, waits for every predicted result, then lets the block
  // finish any request that produces nothing before registers may change.
  task automatic settle();
    @(negedge clk);
    elem_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // A run of L2 vectors. Unused register bits and the mean-mode registers
  // get random values, which the L2 path must not care about. A broken phase
  // leaves a vector open; the next register write must discard it.
  task automatic l2_phase(input int vectors, input int max_len, input logic broken);
    int len;
    write_reg(CFG_MODE, {12'($urandom), MODE_L2});
    if ($urandom_range(0, 1)) write_reg(CFG_CHANNELS, CFG_DATA_BITS'($urandom));
    if ($urandom_range(0, 1)) write_reg(CFG_PLANE, CFG_DATA_BITS'($urandom));
    for (int v = 0; v < vectors; v++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4 * max_len)
                                        : $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) send_item(pick_sample(), i == len - 1);
    end
    if (broken) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) send_item(pick_sample(), 1'b0);
    end
    settle();
  endtask

  // Whole planes in channel-major order. The end_of_vector bit is random
  // since mean mode ignores it. Raw register values go out as given, so
  // out-of-range counts reach the block; the loop sizes follow the clamp.
  task automatic mean_phase(input int channels_raw, input int plane_raw, input int planes,
                            input logic fixed_on, input sample_t fixed_value,
                            input logic broken);
    int used_channels;
    int used_plane;
    int partial;
    used_channels = channels_raw % 512;
    if (used_channels < 2) used_channels = 2;
    if (used_channels > CHANNEL_MAX_DEFAULT) used_channels = CHANNEL_MAX_DEFAULT;
    used_plane = plane_raw % 8192;
    if (used_plane < 1) used_plane = 1;
    if (used_plane > PLANE_MAX_DEFAULT) used_plane = PLANE_MAX_DEFAULT;
    write_reg(CFG_MODE, {12'($urandom), MODE_MEAN});
    write_reg(CFG_CHANNELS, {4'($urandom), 9'(channels_raw)});
    write_reg(CFG_PLANE, CFG_DATA_BITS'(plane_raw));
    repeat (planes) begin
      repeat (used_channels * used_plane)
        send_item(fixed_on ? fixed_value : pick_sample(), 1'($urandom));
    end
    // A plane cut short leaves the accumulators half filled; the next phase
    // starts over from channel 0.
    if (broken) begin
      partial = $urandom_range(1, used_channels * used_plane - 1);
      repeat (partial) send_item(pick_sample(), 1'($urandom));
    end
    settle();
  endtask

  // The receiver cycles through ready patterns of random length: always
  // ready, coin flips, mostly stalled, and a fixed duty cycle. On request it
  // holds off for a long stretch so the block backs up and stalls its input.
  initial begin : receiver
    int style;
    int span;
    res_ch.ready = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 120);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          res_ch.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
        end
        case (style)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom);
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ((k % 8) < 5);
        endcase
      end
    end
  end

  initial begin : stimulus
    int random_start;
    int pick;
    int channels_raw;
    int plane_raw;
    int planes;
    elem_ch.valid         = 1'b0;
    elem_ch.sample        = '0;
    elem_ch.end_of_vector = 1'b0;
    cfg_write             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed L2 vectors under the reset configuration: zero, both
    // extremes, one, and a vector of mixed signs.
    send_item('0, 1'b1);
    send_item(SAMPLE_MIN, 1'b1);
    send_item(SAMPLE_MAX, 1'b1);
    send_item(sample_t'(1), 1'b1);
    send_item(sample_t'(-1), 1'b0);
    send_item(sample_t'(3), 1'b0);
    send_item(sample_t'(-4), 1'b1);

    // A write to the unused index in the middle of a vector must not
    // restart it, so the closing element still sees the earlier squares.
    send_item(sample_t'(256), 1'b0);
    send_item(sample_t'(-256), 1'b0);
    send_item(sample_t'(512), 1'b0);
    settle();
    write_reg(CFG_UNUSED, '1);
    send_item('0, 1'b1);
    settle();

    // Mean mode with both counts below range: the channel count reads as
    // zero in its low bits and clamps to 2, the plane clamps to 1. Covers
    // both extremes of the mean and truncation toward zero on each sign.
    write_reg(CFG_MODE, '1);
    write_reg(CFG_CHANNELS, 13'h1E00);
    write_reg(CFG_PLANE, '0);
    send_item(SAMPLE_MIN, 1'b1);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MAX, 1'b1);
    send_item(sample_t'(-3), 1'b0);
    send_item('0, 1'b0);
    send_item(sample_t'(3), 1'b1);
    send_item('0, 1'b0);
    settle();

    // Three channels over a plane of two: the first position only reports
    // with final_flag low, the second closes the plane.
    write_reg(CFG_CHANNELS, CFG_DATA_BITS'(3));
    write_reg(CFG_PLANE, CFG_DATA_BITS'(2));
    send_item(sample_t'(100), 1'b0);
    send_item(sample_t'(-7), 1'b0);
    send_item(sample_t'(50), 1'b0);
    send_item(sample_t'(8), 1'b0);
    send_item(sample_t'(-151), 1'b0);
    send_item(sample_t'(2), 1'b0);
    settle();

    // Channel count above and at its maximum, one position per plane. The
    // second phase drives the accumulator to its most negative value.
    mean_phase(511, 0, 1, 1'b1, SAMPLE_MAX, 1'b0);
    mean_phase(CHANNEL_MAX_DEFAULT, 1, 1, 1'b1, SAMPLE_MIN, 1'b0);

    // Back pressure: the receiver stops for a long stretch while single
    // element vectors keep coming, so results pile up and input stalls.
    hold_off_req = 1'b1;
    steady       = 1'b1;
    l2_phase(40, 1, 1'b0);
    steady       = 1'b0;

    // Random phases. Mean phases are mostly whole, well-formed planes with
    // small counts; now and then a channel count anywhere in the 9-bit
    // field, with a tiny plane to keep the run short, or a cut-off plane.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 4) begin
        l2_phase($urandom_range(4, 16), 8, $urandom_range(0, 7) == 0);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          channels_raw = $urandom_range(0, 511);
          plane_raw    = $urandom_range(0, 1);
          planes       = 1;
        end else begin
          channels_raw = $urandom_range(2, 6);
          plane_raw    = (pick == 1) ? 0 : $urandom_range(1, 24);
          planes       = $urandom_range(1, 3);
        end
        mean_phase(channels_raw, plane_raw, planes, 1'b0, '0, $urandom_range(0, 4) == 0);
      end
    end

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("l2_norm_and_channel_mean_unit_test passed");
    end else begin
      $display("l2_norm_and_channel_mean_unit_test failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("l2_norm_and_channel_mean_unit_test failed");
    $finish;
  end

endmodule
